// File: hdl/cqre_pkg.sv
package cqre_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 1024;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int PAIR_W      = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLED   = 2'd2;

    // register reset values
    localparam logic [15:0] RETRY_INTERVAL_RST = 16'd100;
    localparam logic [3:0]  RETRY_LIMIT_RST    = 4'd10;
    localparam logic        PORT_ENABLED_RST   = 1'b1;

    // item modes
    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_SVC   = 2'd1,
        MODE_REPLY = 2'd2
    } mode_t;

    // configuration as seen by the core
    typedef struct packed {
        logic [15:0] retry_interval_ms;
        logic [3:0]  retry_limit;
        logic        port_enabled;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_cmd;
        logic [7:0] send_value;
        logic       is_resend;
        logic       timed_out;
        logic       overflowed;
        logic       busy_res;
    } res_t;

    // ring pointer advance
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

// File: hdl/cqre_if.sv
interface cqre_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  cmd_byte;
    logic [7:0]  value_byte;
    logic [31:0] now_ms;

    modport source (output valid, mode, cmd_byte, value_byte, now_ms, input ready);
    modport sink   (input valid, mode, cmd_byte, value_byte, now_ms, output ready);
endinterface

interface cqre_out_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] send_cmd;
    logic [7:0] send_value;
    logic       is_resend;
    logic       timed_out;
    logic       overflowed;
    logic       busy_res;

    modport source (output valid, send_valid, send_cmd, send_value, is_resend,
                    timed_out, overflowed, busy_res, input ready);
    modport sink   (input valid, send_valid, send_cmd, send_value, is_resend,
                    timed_out, overflowed, busy_res, output ready);
endinterface

// File: hdl/cqre_ram.sv
module cqre_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: hdl/cqre_core.sv
module cqre_core (
    input  logic          clk,
    input  logic          rst_n,
    input  cqre_pkg::cfg_t cfg,
    cqre_in_if.sink       in_ch,
    cqre_out_if.source    out_ch
);
    import cqre_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [7:0]       pend_cmd_reg, pend_cmd_next;
    logic [7:0]       pend_val_reg, pend_val_next;
    logic [4:0]       resend_cnt_reg, resend_cnt_next;
    logic [31:0]      last_ms_reg, last_ms_next;
    logic [31:0]      now_reg, now_next;
    logic             out_vld_reg, out_vld_next;
    res_t             out_reg, out_next;

    logic              ram_we;
    logic              ram_re;
    logic [PAIR_W-1:0] ram_rdata;
    logic              in_fire;
    logic              emit;
    logic [31:0]       elapsed;
    res_t              res;

    // pair store
    cqre_ram #(
        .DATA_W (PAIR_W),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata ({in_ch.cmd_byte, in_ch.value_byte}),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // handshake
    assign in_ch.ready = (state_reg == S_IDLE) && (!out_vld_reg || out_ch.ready);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign elapsed     = in_ch.now_ms - last_ms_reg;

    // item processing
    always_comb
    begin
        state_next      = state_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_cmd_next   = pend_cmd_reg;
        pend_val_next   = pend_val_reg;
        resend_cnt_next = resend_cnt_reg;
        last_ms_next    = last_ms_reg;
        now_next        = now_reg;
        out_vld_next    = out_vld_reg && !out_ch.ready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        emit            = 1'b0;
        res             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (mode_t'(in_ch.mode))
                        MODE_ENQ:
                        begin
                            ram_we         = 1'b1;
                            wr_ptr_next    = ptr_inc(wr_ptr_reg);
                            res.overflowed = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
                            emit           = 1'b1;
                        end
                        MODE_SVC:
                        begin
                            if (pend_cmd_reg == 8'd0)
                            begin
                                if (rd_ptr_reg != wr_ptr_reg)
                                begin
                                    // dequeue: wait in S_READ for the registered store read
                                    ram_re      = 1'b1;
                                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                                    now_next    = in_ch.now_ms;
                                    state_next  = S_READ;
                                end
                                else
                                    emit = 1'b1;
                            end
                            else if (resend_cnt_reg > {1'b0, cfg.retry_limit})
                            begin
                                res.timed_out   = 1'b1;
                                resend_cnt_next = '0;
                                pend_cmd_next   = 8'd0;
                                emit            = 1'b1;
                            end
                            else if (elapsed > {16'd0, cfg.retry_interval_ms})
                            begin
                                resend_cnt_next = resend_cnt_reg + 5'd1;
                                last_ms_next    = in_ch.now_ms;
                                if (cfg.port_enabled)
                                begin
                                    res.send_valid = 1'b1;
                                    res.is_resend  = 1'b1;
                                    res.send_cmd   = pend_cmd_reg;
                                    res.send_value = pend_val_reg;
                                end
                                emit = 1'b1;
                            end
                            else
                                emit = 1'b1;
                        end
                        MODE_REPLY:
                        begin
                            if (in_ch.cmd_byte == pend_cmd_reg)
                                pend_cmd_next = 8'd0;
                            emit = 1'b1;
                        end
                        default:
                            emit = 1'b1;
                    endcase
                end
            end
            S_READ:
            begin
                if (!out_vld_reg || out_ch.ready)
                begin
                    // all-zero pairs are dropped
                    if (ram_rdata != '0)
                    begin
                        pend_cmd_next   = ram_rdata[15:8];
                        pend_val_next   = ram_rdata[7:0];
                        resend_cnt_next = '0;
                        last_ms_next    = now_reg;
                        if (cfg.port_enabled)
                        begin
                            res.send_valid = 1'b1;
                            res.send_cmd   = ram_rdata[15:8];
                            res.send_value = ram_rdata[7:0];
                        end
                    end
                    state_next = S_IDLE;
                    emit       = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // load the output register
        if (emit)
        begin
            out_next          = res;
            out_next.busy_res = (pend_cmd_next != 8'd0);
            out_vld_next      = 1'b1;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            pend_cmd_reg   <= '0;
            pend_val_reg   <= '0;
            resend_cnt_reg <= '0;
            last_ms_reg    <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_cmd_reg   <= pend_cmd_next;
            pend_val_reg   <= pend_val_next;
            resend_cnt_reg <= resend_cnt_next;
            last_ms_reg    <= last_ms_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        out_reg <= out_next;
    end

    // result channel
    assign out_ch.valid      = out_vld_reg;
    assign out_ch.send_valid = out_reg.send_valid;
    assign out_ch.send_cmd   = out_reg.send_cmd;
    assign out_ch.send_value = out_reg.send_value;
    assign out_ch.is_resend  = out_reg.is_resend;
    assign out_ch.timed_out  = out_reg.timed_out;
    assign out_ch.overflowed = out_reg.overflowed;
    assign out_ch.busy_res   = out_reg.busy_res;

endmodule

// File: hdl/command_queue_retry_engine_top.sv
// Command queue with retry and timeout: pairs are kept in a 1024-entry ring
// store and sent one at a time; the pending command is resent once the retry
// interval is strictly exceeded and dropped with timed_out after more than
// retry_limit resends. Each input item gives exactly one result item. Enqueue,
// reply and service items that do not dequeue load the output register
// directly; a service item that dequeues first waits in S_READ for the
// registered read of the pair store. A new item is taken once the previous
// result has left or is leaving the output register. The store needs no
// clearing pass after reset. The user writes configuration through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; it is not enforced.
module command_queue_retry_engine_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cqre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cqre_pkg::CFG_DATA_W-1:0] cfg_wdata,
    cqre_in_if.sink                        in_ch,
    cqre_out_if.source                     out_ch
);
    import cqre_pkg::*;

    cfg_t cfg_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_interval_ms <= RETRY_INTERVAL_RST;
            cfg_reg.retry_limit       <= RETRY_LIMIT_RST;
            cfg_reg.port_enabled      <= PORT_ENABLED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RETRY_INTERVAL: cfg_reg.retry_interval_ms <= cfg_wdata[15:0];
                CFG_RETRY_LIMIT:    cfg_reg.retry_limit       <= cfg_wdata[3:0];
                CFG_PORT_ENABLED:   cfg_reg.port_enabled      <= cfg_wdata[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // queue and retry engine
    cqre_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // a disabled port never sends
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !cfg_reg.port_enabled) |-> !out_ch.send_valid)
        else $error("send while port disabled");

    // an accepted item yields a result or holds off the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (out_ch.valid || !in_ch.ready))
        else $error("accepted item lost");

    // a timeout drops the pending command and sends nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.timed_out) |-> (!out_ch.busy_res && !out_ch.send_valid))
        else $error("timeout with command still pending");

    // overflow comes only from an enqueue
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.overflowed) |-> (!out_ch.send_valid && !out_ch.timed_out))
        else $error("overflow on non-enqueue result");

endmodule

// File: tb/tb_command_queue_retry_engine_top.sv
`timescale 1ns / 100ps

module tb_command_queue_retry_engine_top;
    import cqre_pkg::*;

    // mode code that the block leaves undecoded
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  cmd;
        logic [7:0]  val;
        logic [31:0] now;
    } cmd_item_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cmd_item_t              it;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_data;
        bit                     known;
        res_t                   want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cqre_in_if  in_ch();
    cqre_out_if out_ch();

    command_queue_retry_engine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic [PAIR_W-1:0] m_store [QUEUE_DEPTH];
    logic [PTR_W-1:0]  m_wr;
    logic [PTR_W-1:0]  m_rd;
    logic [7:0]        m_cmd;
    logic [7:0]        m_val;
    logic [4:0]        m_tries;
    logic [31:0]       m_sent_at;
    cfg_t              m_cfg;

    res_t        due_results[$];
    plan_row_t   plan[$];
    int          errors;
    int          results_seen;
    bit          calm;
    logic [31:0] ms_clock;
    int          stall_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("tb_command_queue_retry_engine_top failed");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic cmp(string name, logic [7:0] got_v, logic [7:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("result %0d %s: got %0h want %0h",
                                      results_seen, name, got_v, want_v));
    endtask

    // expected response of the engine to one item, updates predictor state
    function automatic res_t engine_response(cmd_item_t it);
        res_t        r;
        logic [15:0] pair;
        logic [31:0] elapsed;
        r = '0;
        case (it.mode)
            MODE_ENQ:
            begin
                m_store[m_wr] = {it.cmd, it.val};
                m_wr = PTR_W'(m_wr + 1);
                if (m_wr == m_rd)
                    r.overflowed = 1'b1;
            end
            MODE_SVC:
            begin
                if (m_cmd == 8'd0)
                begin
                    pair = '0;
                    if (m_rd != m_wr)
                    begin
                        pair = m_store[m_rd];
                        m_rd = PTR_W'(m_rd + 1);
                    end
                    if (pair != 16'd0)
                    begin
                        m_cmd   = pair[15:8];
                        m_val   = pair[7:0];
                        m_tries = '0;
                        if (m_cfg.port_enabled)
                        begin
                            r.send_valid = 1'b1;
                            r.send_cmd   = m_cmd;
                            r.send_value = m_val;
                        end
                        m_sent_at = it.now;
                    end
                end
                else if (m_tries > {1'b0, m_cfg.retry_limit})
                begin
                    r.timed_out = 1'b1;
                    m_tries     = '0;
                    m_cmd       = 8'd0;
                end
                else
                begin
                    elapsed = it.now - m_sent_at;
                    if (elapsed > {16'd0, m_cfg.retry_interval_ms})
                    begin
                        m_tries = m_tries + 5'd1;
                        if (m_cfg.port_enabled)
                        begin
                            r.send_valid = 1'b1;
                            r.is_resend  = 1'b1;
                            r.send_cmd   = m_cmd;
                            r.send_value = m_val;
                        end
                        m_sent_at = it.now;
                    end
                end
            end
            MODE_REPLY:
            begin
                if (it.cmd == m_cmd)
                    m_cmd = 8'd0;
            end
            default:
            begin
            end
        endcase
        r.busy_res = (m_cmd != 8'd0);
        return r;
    endfunction

    // offer one item, wait for acceptance, record what should come back
    task automatic send_item(cmd_item_t it, bit known, res_t want);
        int   gap;
        int   r;
        res_t pred;
        gap = 0;
        if (!calm)
        begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 40);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= it.mode;
        in_ch.cmd_byte   <= it.cmd;
        in_ch.value_byte <= it.val;
        in_ch.now_ms     <= it.now;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pred = engine_response(it);
        due_results.push_back(known ? want : pred);
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_RETRY_INTERVAL: m_cfg.retry_interval_ms = data;
            CFG_RETRY_LIMIT:    m_cfg.retry_limit       = data[3:0];
            CFG_PORT_ENABLED:   m_cfg.port_enabled      = data[0];
            default:
            begin
            end
        endcase
    endtask

    // all three registers, junk in the unused upper bits
    task automatic set_regs(logic [15:0] interval, logic [3:0] limit, logic en);
        logic [15:0] junk;
        drain_results();
        junk = 16'($urandom);
        write_cfg(CFG_RETRY_INTERVAL, interval);
        write_cfg(CFG_RETRY_LIMIT, (junk & 16'hfff0) | 16'(limit));
        write_cfg(CFG_PORT_ENABLED, (junk & 16'hfffe) | 16'(en));
        ms_clock = $urandom;
    endtask

    function automatic res_t mk_res(bit sv, logic [7:0] c, logic [7:0] v, bit rs, bit to,
                                    bit ov, bit busy);
        res_t r;
        r.send_valid = sv;
        r.send_cmd   = c;
        r.send_value = v;
        r.is_resend  = rs;
        r.timed_out  = to;
        r.overflowed = ov;
        r.busy_res   = busy;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] mode, logic [7:0] cmd, logic [7:0] val,
                                    logic [31:0] now, bit known, res_t want);
        plan_row_t row;
        row.kind     = ROW_ITEM;
        row.it.mode  = mode;
        row.it.cmd   = cmd;
        row.it.val   = val;
        row.it.now   = now;
        row.cfg_idx  = '0;
        row.cfg_data = '0;
        row.known    = known;
        row.want     = want;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.kind     = ROW_CFG;
        row.it.mode  = '0;
        row.it.cmd   = '0;
        row.it.val   = '0;
        row.it.now   = '0;
        row.cfg_idx  = idx;
        row.cfg_data = data;
        row.known    = 1'b0;
        row.want     = '0;
        plan.push_back(row);
    endfunction

    // random traffic: mostly enqueue, service and matching replies
    task automatic run_random(int count);
        cmd_item_t   it;
        int          r;
        int unsigned iv;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(0, 79) == 0)
                drain_results();
            r      = $urandom_range(0, 99);
            it.cmd = 8'($urandom);
            it.val = 8'($urandom);
            it.now = $urandom;
            if (r < 30)
            begin
                it.mode = MODE_ENQ;
                if ($urandom_range(0, 19) == 0)
                begin
                    it.cmd = 8'd0;
                    it.val = 8'd0;
                end
                else if ($urandom_range(0, 9) == 0)
                    it.cmd = 8'd0;
            end
            else if (r < 75)
            begin
                it.mode = MODE_SVC;
                iv = m_cfg.retry_interval_ms;
                r  = $urandom_range(0, 99);
                if (r < 80)
                    ms_clock = ms_clock + $urandom_range(0, iv + iv / 2 + 3);
                else if (r < 90)
                    ms_clock = ms_clock + $urandom_range(iv, iv + 1);
                else
                    ms_clock = ms_clock + $urandom;
                it.now = ms_clock;
            end
            else if (r < 93)
            begin
                it.mode = MODE_REPLY;
                if ($urandom_range(0, 9) < 7)
                    it.cmd = m_cmd;
            end
            else
                it.mode = $urandom_range(0, 1) ? MODE_UNDEF : 2'($urandom);
            send_item(it, 1'b0, '0);
        end
    endtask

    // result side: random back-pressure and checking
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        int   r;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.send_valid = out_ch.send_valid;
            got.send_cmd   = out_ch.send_cmd;
            got.send_value = out_ch.send_value;
            got.is_resend  = out_ch.is_resend;
            got.timed_out  = out_ch.timed_out;
            got.overflowed = out_ch.overflowed;
            got.busy_res   = out_ch.busy_res;
            if (due_results.size() == 0)
                report_mismatch($sformatf("result %0d with no item waiting", results_seen));
            else
            begin
                want = due_results.pop_front();
                cmp("send_valid", got.send_valid, want.send_valid);
                cmp("send_cmd",   got.send_cmd,   want.send_cmd);
                cmp("send_value", got.send_value, want.send_value);
                cmp("is_resend",  got.is_resend,  want.is_resend);
                cmp("timed_out",  got.timed_out,  want.timed_out);
                cmp("overflowed", got.overflowed, want.overflowed);
                cmp("busy_res",   got.busy_res,   want.busy_res);
            end
            results_seen++;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (calm)
            out_ch.ready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r >= 94)
            begin
                stall_left   = $urandom_range(8, 40);
                out_ch.ready <= 1'b0;
            end
            else if (r >= 72)
            begin
                stall_left   = $urandom_range(0, 2);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // main sequence
    initial
    begin
        cmd_item_t it;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_ENQ;
        in_ch.cmd_byte   = '0;
        in_ch.value_byte = '0;
        in_ch.now_ms     = '0;
        out_ch.ready     = 1'b0;
        errors       = 0;
        results_seen = 0;
        calm         = 1'b0;
        stall_left   = 0;
        ms_clock     = '0;
        m_wr      = '0;
        m_rd      = '0;
        m_cmd     = '0;
        m_val     = '0;
        m_tries   = '0;
        m_sent_at = '0;
        m_cfg.retry_interval_ms = RETRY_INTERVAL_RST;
        m_cfg.retry_limit       = RETRY_LIMIT_RST;
        m_cfg.port_enabled      = PORT_ENABLED_RST;
        foreach (m_store[i])
            m_store[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, flags, special pairs, wrap, timeout, port off
        add_row(MODE_SVC,   8'h00, 8'h00, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_REPLY, 8'h00, 8'h00, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_UNDEF, 8'hff, 8'hff, 32'hffff_ffff, 1,
                mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_ENQ,   8'hff, 8'hff, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_ENQ,   8'h00, 8'h00, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_ENQ,   8'h00, 8'h5a, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_ENQ,   8'h01, 8'h00, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_ENQ,   8'h80, 8'h01, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd10, 1, mk_res(1, 8'hff, 8'hff, 0, 0, 0, 1));
        // interval reached but not exceeded
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd110, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 1));
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd111, 1, mk_res(1, 8'hff, 8'hff, 1, 0, 0, 1));
        add_row(MODE_REPLY, 8'hfe, 8'h00, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 1));
        add_row(MODE_REPLY, 8'hff, 8'h00, 32'h0, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        // all-zero pair dropped, zero command sent untracked
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd200, 1, mk_res(0, 8'h00, 8'h00, 0, 0, 0, 0));
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd300, 1, mk_res(1, 8'h00, 8'h5a, 0, 0, 0, 0));
        add_row(MODE_SVC,   8'h00, 8'h00, 32'hffff_fff0, 1,
                mk_res(1, 8'h01, 8'h00, 0, 0, 0, 1));
        // elapsed time across the wrap of the millisecond clock
        add_row(MODE_SVC,   8'h00, 8'h00, 32'h0000_0060, 0, '0);
        add_row(MODE_REPLY, 8'h01, 8'h00, 32'h0, 0, '0);
        add_cfg(CFG_RETRY_LIMIT, 16'h0);
        add_cfg(CFG_RETRY_INTERVAL, 16'h0);
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd5, 0, '0);
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd5, 0, '0);
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd6, 0, '0);
        add_row(MODE_SVC,   8'h00, 8'h00, 32'd6, 1, mk_res(0, 8'h00, 8'h00, 0, 1, 0, 0));
        // port disabled: silent sends, bookkeeping still runs
        add_cfg(CFG_PORT_ENABLED, 16'h0);
        add_row(MODE_ENQ,   8'h12, 8'h34, 32'h0, 0, '0);
        add_row(MODE_SVC,   8'h00, 8'h00, 32'hffff_ffff, 0, '0);
        add_row(MODE_SVC,   8'h00, 8'h00, 32'h0, 0, '0);
        add_row(MODE_REPLY, 8'h12, 8'h00, 32'h0, 0, '0);
        add_cfg(CFG_RETRY_INTERVAL, 16'hffff);
        add_cfg(CFG_RETRY_LIMIT, 16'hffff);
        add_cfg(CFG_PORT_ENABLED, 16'hffff);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_cfg(plan[i].cfg_idx, plan[i].cfg_data);
            end
            else
                send_item(plan[i].it, plan[i].known, plan[i].want);
        end

        // deep queue: fill, serve a few, then push until the pointers meet
        set_regs(RETRY_INTERVAL_RST, RETRY_LIMIT_RST, 1'b1);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            it.mode = MODE_ENQ;
            it.cmd  = 8'($urandom_range(1, 255));
            it.val  = 8'($urandom);
            it.now  = $urandom;
            send_item(it, 1'b0, '0);
        end
        for (int i = 0; i < 40; i++)
        begin
            it.val = 8'($urandom);
            if (i % 2 == 0)
            begin
                it.mode  = MODE_SVC;
                ms_clock = ms_clock + 1;
                it.now   = ms_clock;
                it.cmd   = 8'($urandom);
            end
            else
            begin
                it.mode = MODE_REPLY;
                it.cmd  = m_cmd;
                it.now  = $urandom;
            end
            send_item(it, 1'b0, '0);
        end
        for (int i = 0; i < 40; i++)
        begin
            it.mode = MODE_ENQ;
            it.cmd  = 8'($urandom);
            it.val  = 8'($urandom);
            it.now  = $urandom;
            send_item(it, 1'b0, '0);
        end

        // random phases across register settings
        set_regs(16'd0, 4'd0, 1'b1);
        run_random(110);
        set_regs(16'hffff, 4'd15, 1'b1);
        run_random(110);
        set_regs(16'($urandom_range(1, 300)), 4'($urandom_range(0, 15)), 1'b0);
        run_random(110);
        set_regs(16'($urandom_range(20, 200)), 4'($urandom_range(0, 15)), 1'b1);
        run_random(110);
        calm = 1'b1;
        set_regs(RETRY_INTERVAL_RST, RETRY_LIMIT_RST, 1'b1);
        run_random(110);
        calm = 1'b0;
        set_regs(16'($urandom_range(0, 50)), 4'd15, 1'b1);
        run_random(110);

        // wait out the tail
        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_command_queue_retry_engine_top passed");
        else
            $display("tb_command_queue_retry_engine_top failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/cqre_pkg.sv
hdl/cqre_if.sv
hdl/cqre_ram.sv
hdl/cqre_core.sv
hdl/command_queue_retry_engine_top.sv
tb/tb_command_queue_retry_engine_top.sv
